// File: rtl/ffsl_pkg.sv
// ----------------------------------------------------------------------------
// ffsl_pkg
// Types, constants and the byte filter shared by the full-width fold / strip /
// lowercase normalizer.
// ----------------------------------------------------------------------------
package ffsl_pkg;

    localparam logic [7:0]  LEAD_SPACE  = 8'hE3;
    localparam logic [7:0]  CONT_SPACE  = 8'h80;
    localparam logic [7:0]  LEAD_WIDE   = 8'hEF;
    localparam logic [15:0] WIDE_LOW    = 16'hBC81;
    localparam logic [15:0] WIDE_HIGH   = 16'hBD9E;
    localparam logic [7:0]  UPPER_A     = 8'h41;
    localparam logic [7:0]  UPPER_Z     = 8'h5A;
    localparam logic [7:0]  CASE_OFFSET = 8'h20;
    localparam logic [7:0]  WS_SPACE    = 8'h20;
    localparam logic [7:0]  WS_TAB      = 8'h09;
    localparam logic [7:0]  WS_LF       = 8'h0A;
    localparam logic [7:0]  WS_CR       = 8'h0D;

    localparam int MAX_RESULTS = 3;
    localparam int FIFO_DEPTH  = 4;
    localparam int PTR_W       = $clog2(FIFO_DEPTH);
    localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);
    localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

    typedef struct packed {
        logic       keep;
        logic [7:0] value;
    } cand_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       end_of_string;
    } result_t;

    function automatic cand_t filter_byte(input logic [7:0] c);
        cand_t r;
        r.keep  = !((c == WS_SPACE) || (c == WS_TAB) || (c == WS_LF) || (c == WS_CR));
        r.value = ((c >= UPPER_A) && (c <= UPPER_Z)) ? 8'(c + CASE_OFFSET) : c;
        return r;
    endfunction

endpackage

// File: rtl/ffsl_text_if.sv
// ----------------------------------------------------------------------------
// ffsl_text_if
// Input byte channel: one UTF-8 byte per transfer, flag on the last byte.
// ----------------------------------------------------------------------------
interface ffsl_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       is_last;

    modport source (output valid, output in_byte, output is_last, input ready);
    modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

// File: rtl/ffsl_norm_if.sv
// ----------------------------------------------------------------------------
// ffsl_norm_if
// Result channel: one normalized byte or end marker per transfer.
// ----------------------------------------------------------------------------
interface ffsl_norm_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_string;

    modport source (output valid, output out_byte, output byte_valid,
                    output end_of_string, input ready);
    modport sink   (input valid, input out_byte, input byte_valid,
                    input end_of_string, output ready);
endinterface

// File: rtl/fullwidth_fold_strip_lowercase.sv
// ----------------------------------------------------------------------------
// fullwidth_fold_strip_lowercase
// Streaming UTF-8 normalizer: drops ideographic space, folds full-width forms
// to ASCII, strips white space and lowers ASCII capitals.
//
// text: one non-zero byte per transfer, is_last set on the final byte.
// norm: normalized bytes; end_of_string marks the last result of a string,
//       and a string that yields nothing gives one item with byte_valid low.
// Up to two bytes are held back to see three-byte sequences; at the last
// byte the held bytes are flushed, so one input transfer makes 0 to 3
// results.
// Results are registered in a 4-entry result FIFO and offered from its head.
// Throughput: one input byte per cycle; the FIFO takes the up-to-3 results
// of a flush and accepts input while it has room for 3, so only a string
// end or a stalled receiver slows the input.
// Reset clears the held bytes and empties the FIFO. When norm stalls, results
// wait in the FIFO and text.ready drops once fewer than 3 entries are free.
// ----------------------------------------------------------------------------
module fullwidth_fold_strip_lowercase (
    input logic         clk,
    input logic         rst_n,
    ffsl_text_if.sink   text,
    ffsl_norm_if.source norm
);
    import ffsl_pkg::*;

    logic [7:0]          pend0_reg, pend0_next;
    logic [7:0]          pend1_reg, pend1_next;
    logic [1:0]          pcnt_reg, pcnt_next;
    result_t             fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]    wptr_reg, rptr_reg;
    logic [CNT_W-1:0]    fcnt_reg;
    logic                accept, pop;
    logic                space_seq, wide_hit;
    logic [15:0]         wide_val;
    logic [7:0]          folded, head;
    cand_t               cand [MAX_RESULTS];
    result_t             slot [MAX_RESULTS];
    logic [NRES_W-1:0]   nres, push_n;

    assign accept     = text.valid && text.ready;
    assign pop        = norm.valid && norm.ready;
    assign text.ready = (fcnt_reg <= CNT_W'(FIFO_DEPTH - MAX_RESULTS));

    assign norm.valid         = (fcnt_reg != '0);
    assign norm.out_byte      = fifo_reg[rptr_reg].out_byte;
    assign norm.byte_valid    = fifo_reg[rptr_reg].byte_valid;
    assign norm.end_of_string = fifo_reg[rptr_reg].end_of_string;

    assign space_seq = (pend0_reg == LEAD_SPACE) && (pend1_reg == CONT_SPACE)
                       && (text.in_byte == CONT_SPACE);
    assign wide_val  = {pend1_reg, text.in_byte};
    assign wide_hit  = (pend0_reg == LEAD_WIDE) && (wide_val >= WIDE_LOW)
                       && (wide_val <= WIDE_HIGH);
    assign folded    = CASE_OFFSET + {1'b0, pend1_reg[0], 6'b0}
                       + {2'b0, text.in_byte[5:0]};
    assign head      = wide_hit ? folded : pend0_reg;

    always_comb
    begin
        pend0_next = pend0_reg;
        pend1_next = pend1_reg;
        pcnt_next  = pcnt_reg;
        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            cand[k] = '0;
        end
        if (accept)
        begin
            if (text.is_last)
            begin
                pend0_next = '0;
                pend1_next = '0;
                pcnt_next  = '0;
                case (pcnt_reg)
                    2'd2:
                    begin
                        if (!space_seq)
                        begin
                            cand[0] = filter_byte(head);
                        end
                        if (!space_seq && !wide_hit)
                        begin
                            cand[1] = filter_byte(pend1_reg);
                            cand[2] = filter_byte(text.in_byte);
                        end
                    end
                    2'd1:
                    begin
                        cand[0] = filter_byte(pend0_reg);
                        cand[1] = filter_byte(text.in_byte);
                    end
                    default:
                    begin
                        cand[0] = filter_byte(text.in_byte);
                    end
                endcase
            end
            else
            begin
                case (pcnt_reg)
                    2'd2:
                    begin
                        if (!space_seq)
                        begin
                            cand[0] = filter_byte(head);
                        end
                        if (space_seq || wide_hit)
                        begin
                            pend0_next = '0;
                            pend1_next = '0;
                            pcnt_next  = '0;
                        end
                        else
                        begin
                            pend0_next = pend1_reg;
                            pend1_next = text.in_byte;
                        end
                    end
                    2'd1:
                    begin
                        pend1_next = text.in_byte;
                        pcnt_next  = 2'd2;
                    end
                    default:
                    begin
                        pend0_next = text.in_byte;
                        pcnt_next  = 2'd1;
                    end
                endcase
            end
        end
    end

    // compact kept candidates into consecutive result slots
    always_comb
    begin
        nres = '0;
        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            slot[k] = '0;
        end
        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            if (cand[k].keep)
            begin
                slot[nres[1:0]] = '{out_byte: cand[k].value, byte_valid: 1'b1,
                                    end_of_string: 1'b0};
                nres = nres + 1'b1;
            end
        end
        if (accept && text.is_last)
        begin
            if (nres == '0)
            begin
                slot[0] = '{out_byte: 8'h00, byte_valid: 1'b0, end_of_string: 1'b1};
                nres    = NRES_W'(1);
            end
            else
            begin
                slot[2'(nres - 1'b1)].end_of_string = 1'b1;
            end
        end
        push_n = accept ? nres : '0;
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            if (NRES_W'(k) < push_n)
            begin
                fifo_reg[PTR_W'(wptr_reg + PTR_W'(k))] <= slot[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend0_reg <= '0;
            pend1_reg <= '0;
            pcnt_reg  <= '0;
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            fcnt_reg  <= '0;
        end
        else
        begin
            pend0_reg <= pend0_next;
            pend1_reg <= pend1_next;
            pcnt_reg  <= pcnt_next;
            wptr_reg  <= PTR_W'(wptr_reg + PTR_W'(push_n));
            if (pop)
            begin
                rptr_reg <= PTR_W'(rptr_reg + 1'b1);
            end
            fcnt_reg  <= CNT_W'(fcnt_reg + CNT_W'(push_n) - CNT_W'(pop));
        end
    end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the full-width fold / strip / lowercase normalizer. Directed
// strings hit ideographic space, full-width range edges, folded blanks,
// short tails and empty results. Random strings are built mostly from
// well-formed sequences. Expected bytes come from a scoreboard that keeps its
// own copy of the held-byte window, and are checked in order on every result
// transfer. The idle and stall mix changes by phase, with one long receiver
// hold and drains between phases.
// ----------------------------------------------------------------------------
module tb_top;
    import ffsl_pkg::*;

    localparam logic [7:0]  FOLD_BASE = 8'h20;
    localparam logic [15:0] FOLD_BIT  = 16'h0100;
    localparam logic [15:0] FOLD_MASK = 16'h003F;
    localparam int          IDLE_LIMIT = 2000;
    localparam int          SETTLE_CYCLES = 10;

    logic clk;
    logic rst_n;

    ffsl_text_if text ();
    ffsl_norm_if norm ();

    fullwidth_fold_strip_lowercase uut (
        .clk   (clk),
        .rst_n (rst_n),
        .text  (text.sink),
        .norm  (norm.source)
    );

    class norm_scoreboard;
        result_t    expected_q[$];
        logic [7:0] held[2];
        int         held_cnt;
        int         errors;

        function new();
            held[0]  = '0;
            held[1]  = '0;
            held_cnt = 0;
            errors   = 0;
        endfunction

        function void report(string what, result_t want, result_t got);
            errors++;
            if (errors <= 10)
                $display("%0t: %s: expected byte=%h valid=%b end=%b, got byte=%h valid=%b end=%b",
                         $realtime, what, want.out_byte, want.byte_valid, want.end_of_string,
                         got.out_byte, got.byte_valid, got.end_of_string);
        endfunction

        // Predict the results of one accepted byte.
        function void note_byte(logic [7:0] b, logic is_end);
            logic [7:0]  win[3];
            logic [7:0]  outs[3];
            logic [7:0]  c;
            logic [15:0] v;
            logic        keep;
            int          len;
            int          pos;
            int          n;
            int          used;
            result_t     r;
            len = 0;
            pos = 0;
            n   = 0;
            for (int i = 0; i < held_cnt; i++)
                win[len++] = held[i];
            win[len++] = b;
            while (len - pos > 0) begin
                if (len - pos < 3 && !is_end)
                    break;
                used = 1;
                keep = 1'b1;
                c    = win[pos];
                if (len - pos >= 3) begin
                    if (win[pos] == LEAD_SPACE && win[pos+1] == CONT_SPACE &&
                        win[pos+2] == CONT_SPACE) begin
                        used = 3;
                        keep = 1'b0;
                    end else if (win[pos] == LEAD_WIDE) begin
                        v = {win[pos+1], win[pos+2]};
                        if (v >= WIDE_LOW && v <= WIDE_HIGH) begin
                            v    = 16'(FOLD_BASE) + ((v & FOLD_BIT) >> 2) + (v & FOLD_MASK);
                            c    = v[7:0];
                            used = 3;
                        end
                    end
                end
                if (keep) begin
                    if (c == WS_SPACE || c == WS_TAB || c == WS_LF || c == WS_CR)
                        keep = 1'b0;
                    else if (c >= UPPER_A && c <= UPPER_Z)
                        c = c + CASE_OFFSET;
                end
                if (keep)
                    outs[n++] = c;
                pos += used;
                if (!is_end)
                    break;
            end
            if (is_end) begin
                held[0]  = '0;
                held[1]  = '0;
                held_cnt = 0;
                if (n == 0) begin
                    r.out_byte      = '0;
                    r.byte_valid    = 1'b0;
                    r.end_of_string = 1'b1;
                    expected_q.push_back(r);
                end
                for (int i = 0; i < n; i++) begin
                    r.out_byte      = outs[i];
                    r.byte_valid    = 1'b1;
                    r.end_of_string = (i == n - 1);
                    expected_q.push_back(r);
                end
            end else begin
                held_cnt = len - pos;
                held[0]  = (held_cnt > 0) ? win[pos] : '0;
                held[1]  = (held_cnt > 1) ? win[pos+1] : '0;
                for (int i = 0; i < n; i++) begin
                    r.out_byte      = outs[i];
                    r.byte_valid    = 1'b1;
                    r.end_of_string = 1'b0;
                    expected_q.push_back(r);
                end
            end
        endfunction

        function void check(result_t got);
            result_t want;
            if (expected_q.size() == 0) begin
                want = '0;
                report("unexpected result", want, got);
            end else begin
                want = expected_q.pop_front();
                if (want != got)
                    report("mismatch", want, got);
            end
        endfunction

        function void finish_check();
            result_t none;
            none = '0;
            while (expected_q.size() > 0)
                report("missing result", expected_q.pop_front(), none);
        endfunction
    endclass

    norm_scoreboard sb = new();

    int tx_idle_pct;
    int rx_stall_pct;
    int rx_hold;
    int idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: random stalls, plus a long hold-off on request.
    initial
    begin
        norm.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0) begin
                norm.ready <= 1'b0;
                rx_hold--;
            end else begin
                norm.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && norm.valid && norm.ready) begin
            got.out_byte      = norm.out_byte;
            got.byte_valid    = norm.byte_valid;
            got.end_of_string = norm.end_of_string;
            sb.check(got);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((text.valid && text.ready) || (norm.valid && norm.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic is_end);
        while ($urandom_range(99) < tx_idle_pct) begin
            text.valid <= 1'b0;
            @(negedge clk);
        end
        text.valid   <= 1'b1;
        text.in_byte <= b;
        text.is_last <= is_end;
        @(posedge clk);
        while (!text.ready)
            @(posedge clk);
        sb.note_byte(b, is_end);
        @(negedge clk);
    endtask

    task automatic send_string(input logic [7:0] s[$]);
        foreach (s[i])
            send_byte(s[i], i == s.size() - 1);
    endtask

    task automatic drain();
        text.valid <= 1'b0;
        @(negedge clk);
        while (sb.expected_q.size() > 0)
            @(negedge clk);
    endtask

    task automatic run_phase(input int nbytes, input bit long_hold);
        logic [7:0] s[$];
        int         total;
        int         len;
        int         kind;
        bit         held_off;
        total    = 0;
        held_off = 0;
        while (total < nbytes) begin
            s.delete();
            len = ($urandom_range(9) == 0) ? $urandom_range(20, 8) : $urandom_range(10, 1);
            while (s.size() < len) begin
                kind = $urandom_range(99);
                if (kind < 15) begin
                    s.push_back(LEAD_SPACE);
                    s.push_back(CONT_SPACE);
                    s.push_back(CONT_SPACE);
                end else if (kind < 40) begin
                    s.push_back(LEAD_WIDE);
                    if ($urandom_range(1)) begin
                        s.push_back(8'hBC);
                        s.push_back(8'($urandom_range(8'hFF, 8'h80)));
                    end else begin
                        s.push_back(8'hBD);
                        s.push_back(8'($urandom_range(8'h9F, 8'h00)));
                    end
                end else if (kind < 47) begin
                    s.push_back(LEAD_WIDE);
                    s.push_back(8'($urandom_range(255, 1)));
                    s.push_back(8'($urandom_range(255, 1)));
                end else if (kind < 54) begin
                    s.push_back(LEAD_SPACE);
                    s.push_back($urandom_range(1) ? CONT_SPACE : 8'($urandom_range(255, 1)));
                end else if (kind < 64) begin
                    case ($urandom_range(3))
                        0: s.push_back(WS_SPACE);
                        1: s.push_back(WS_TAB);
                        2: s.push_back(WS_LF);
                        default: s.push_back(WS_CR);
                    endcase
                end else if (kind < 76) begin
                    s.push_back(8'($urandom_range(UPPER_Z, UPPER_A)));
                end else begin
                    s.push_back(8'($urandom_range(255, 1)));
                end
            end
            if (long_hold && !held_off && total >= nbytes / 2) begin
                rx_hold  = 80;
                held_off = 1;
            end
            send_string(s);
            total += s.size();
        end
        drain();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        text.valid   = 1'b0;
        text.in_byte = '0;
        text.is_last = 1'b0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold      = 0;
        idle_cycles  = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_string('{LEAD_SPACE, CONT_SPACE, CONT_SPACE, UPPER_A});
        send_string('{LEAD_WIDE, 8'hBC, 8'h81, LEAD_WIDE, 8'hBD, 8'h9E});
        send_string('{LEAD_WIDE, 8'hBC, 8'hC0, LEAD_WIDE, 8'hBD, 8'h9F});
        send_string('{WS_SPACE, WS_TAB, WS_LF, WS_CR});
        send_string('{LEAD_SPACE, CONT_SPACE});
        send_string('{8'h01, 8'hFF, UPPER_Z});
        drain();

        run_phase(112, 1);
        tx_idle_pct = 73;
        run_phase(112, 0);
        tx_idle_pct  = 0;
        rx_stall_pct = 73;
        run_phase(112, 0);
        tx_idle_pct  = 17;
        rx_stall_pct = 17;
        run_phase(112, 0);

        repeat (SETTLE_CYCLES) @(posedge clk);
        sb.finish_check();
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
